FILE: hdl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int Rounds = 64;

    localparam logic [7:0] PadMarker = 8'h80;
    localparam logic [5:0] LengthStart = 6'd56;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic       buf_write;
        logic [5:0] buf_addr;
        logic [7:0] buf_data;
        logic       count_inc;
        logic       round_start;
        logic       round_step;
        logic       hash_update;
        logic       hash_reset;
        logic [5:0] round_idx;
        logic       load_len;
    } dp_cmd_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        init_h = h;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte word is taken while the hasher is idle; the 64th byte of a block holds
// input while the shared round unit runs 64 rounds plus load and add.
// The end of a message pads one byte per cycle and runs one or two blocks,
// then shows eight digest words, one per cycle unless stalled.
// Reset is asynchronous and active low; it restores the initial hash values.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    output out_word_t      out_data,
    output logic           out_valid,
    input  wire logic      out_stall
);

    dp_cmd_t     cmd;
    logic [2:0]  sel;
    logic [31:0] hash_word;

    sha256_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_sel   (sel),
        .cmd       (cmd)
    );

    sha256_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_sel  (sel),
        .hash_out (hash_word)
    );

    assign out_data.digest_word = hash_word;
    assign out_data.word_index  = sel;
    assign out_data.last_word   = (sel == 3'd7);

endmodule
`default_nettype wire

FILE: hdl/sha256_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [2:0]  out_sel,
    output logic      [31:0] hash_out
);

    logic [31:0] buf_mem [0:15];
    logic [31:0] sched_reg [0:15];
    logic [31:0] hash_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [63:0] count_reg;
    logic [63:0] bits;
    logic [31:0] w_cur;
    logic [31:0] a15, a2, sg0, sg1, big0, big1, ch, maj, t1, t2;
    logic [3:0]  widx;

    assign bits = {count_reg[60:0], 3'b000};
    assign widx = cmd.round_idx[3:0];
    assign a15  = sched_reg[widx + 4'd1];
    assign a2   = sched_reg[widx + 4'd14];
    assign sg0  = ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3);
    assign sg1  = ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10);

    always_comb
    begin
        if (cmd.round_idx < 6'd16)
        begin
            w_cur = buf_mem[widx];
        end
        else
        begin
            w_cur = sched_reg[widx] + sg0 + sched_reg[widx + 4'd9] + sg1;
        end
    end

    assign big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + round_k(cmd.round_idx) + w_cur;
    assign big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    assign hash_out = hash_reg[out_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
        begin
            case (cmd.buf_addr[1:0])
                2'd0: buf_mem[cmd.buf_addr[5:2]][31:24] <= cmd.buf_data;
                2'd1: buf_mem[cmd.buf_addr[5:2]][23:16] <= cmd.buf_data;
                2'd2: buf_mem[cmd.buf_addr[5:2]][15:8] <= cmd.buf_data;
                default: buf_mem[cmd.buf_addr[5:2]][7:0] <= cmd.buf_data;
            endcase
        end
        else if (cmd.load_len)
        begin
            buf_mem[14] <= bits[63:32];
            buf_mem[15] <= bits[31:0];
        end
        if (cmd.round_step)
        begin
            sched_reg[widx] <= w_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_h(3'(i));
                v_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.hash_reset)
            begin
                count_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_h(3'(i));
                end
            end
            else
            begin
                if (cmd.count_inc)
                begin
                    count_reg <= count_reg + 64'd1;
                end
                if (cmd.hash_update)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
            end
            if (cmd.round_start)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
            else if (cmd.round_step)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sha256_control.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_control
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [2:0]    out_sel,
    output dp_cmd_t       cmd
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StInit  = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StAdd   = 3'd3;
    localparam logic [2:0] StPad   = 3'd4;
    localparam logic [2:0] StOut   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] sel_reg, sel_next;
    logic       fin_reg, fin_next;
    logic       len_reg, len_next;
    logic       accept;

    assign in_stall  = (state_reg != StIdle);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == StOut);
    assign out_sel   = sel_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        sel_next   = sel_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.round_idx = round_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    fin_next = in_data.end_of_message;
                    len_next = 1'b0;
                    if (in_data.byte_valid)
                    begin
                        cmd.buf_write = 1'b1;
                        cmd.buf_addr  = fill_reg;
                        cmd.buf_data  = in_data.byte_value;
                        cmd.count_inc = 1'b1;
                        fill_next     = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = StInit;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_next = StPad;
                        end
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = StPad;
                    end
                end
            end
            StPad:
            begin
                // Pad one byte per cycle; the length fields go in at once.
                cmd.buf_write = 1'b1;
                cmd.buf_addr  = fill_reg;
                cmd.buf_data  = (fill_reg != 6'd0 || !len_reg) && !len_reg ? PadMarker : 8'h00;
                if (len_reg)
                begin
                    cmd.buf_data = 8'h00;
                end
                fill_next = fill_reg + 6'd1;
                len_next  = 1'b1;
                if (fill_reg == 6'd63)
                begin
                    state_next = StInit;
                end
                else if (len_reg && fill_reg == LengthStart - 6'd1)
                begin
                    state_next = StInit;
                    fill_next  = LengthStart;
                end
                else if (!len_reg && fill_reg == LengthStart - 6'd1)
                begin
                    state_next = StInit;
                    fill_next  = LengthStart;
                end
            end
            StInit:
            begin
                if (fin_reg && len_reg && (fill_reg == LengthStart))
                begin
                    cmd.load_len = 1'b1;
                end
                cmd.round_start = 1'b1;
                round_next = '0;
                state_next = StRound;
            end
            StRound:
            begin
                cmd.round_step = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(Rounds - 1))
                begin
                    state_next = StAdd;
                end
            end
            StAdd:
            begin
                cmd.hash_update = 1'b1;
                if (fin_reg && len_reg && fill_reg == LengthStart)
                begin
                    state_next = StOut;
                    sel_next   = '0;
                    fill_next  = '0;
                end
                else if (fin_reg)
                begin
                    state_next = StPad;
                    fill_next  = '0;
                end
                else
                begin
                    state_next = StIdle;
                    fill_next  = '0;
                end
            end
            StOut:
            begin
                if (!out_stall)
                begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'd7)
                    begin
                        cmd.hash_reset = 1'b1;
                        state_next = StIdle;
                        fin_next   = 1'b0;
                        len_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            fill_reg  <= '0;
            round_reg <= '0;
            sel_reg   <= '0;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            sel_reg   <= sel_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sha256_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker
    import sha256_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire in_word_t  in_data,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire out_word_t out_data,
    input wire logic      out_valid,
    input wire logic      out_stall
);

    // Output words never arrive while input is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("output shown while input open");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("digest words out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
        else $error("last word flag wrong");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
`default_nettype wire
